// ===== rtl/core/dht_pkg.sv =====
`timescale 1ns / 1ps
package dht_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [6:0] CAP_RESET = 7'd60;
    localparam logic [6:0] LIMIT_RESET = 7'd45;

    typedef enum logic [1:0] {MARK_EMPTY = 2'd0, MARK_USED = 2'd1, MARK_DELETED = 2'd2}
        mark_t;
    typedef enum logic [2:0] {
        ST_FOUND = 3'd0, ST_NOT_FOUND = 3'd1, ST_INSERTED = 3'd2,
        ST_UPDATED = 3'd3, ST_REMOVED = 3'd4, ST_FULL = 3'd5
    } status_t;
    typedef enum logic [1:0] {MODE_LOOKUP = 2'd0, MODE_WRITE = 2'd1, MODE_REMOVE = 2'd2}
        mode_t;
    typedef enum logic [0:0] {CFG_CAPACITY = 1'b0, CFG_LIMIT = 1'b1} cfg_idx_t;
    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_READ, S_CHECK, S_WRITE, S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } mod_ctl_t;
endpackage

// ===== rtl/core/dht_mod.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring remainder of a 31-bit key by a small divisor.
module dht_mod
    import dht_pkg::*;
#(
    parameter int CW = 7
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [30:0]   dividend,
    input  logic [CW-1:0] divisor,
    output mod_ctl_t      ctl,
    output logic [CW-1:0] rem
);
    logic [30:0]   sh_reg;
    logic [CW:0]   acc_reg;
    logic [4:0]    cnt_reg;
    logic          busy_reg;
    logic [CW:0]   trial;
    logic [CW+1:0] diff;

    always_comb
    begin
        trial = {acc_reg[CW-1:0], sh_reg[30]};
        diff  = {1'b0, trial} - {2'b00, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd30;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[29:0], 1'b0};
            if (!diff[CW+1])
                acc_reg <= diff[CW:0];
            else
                acc_reg <= trial;
        end
    end

    assign rem       = acc_reg[CW-1:0];
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
endmodule

// ===== rtl/core/dht_store.sv =====
`timescale 1ns / 1ps
// Slot key/value memory (one read and one write port) plus slot marks with reset.
module dht_store
    import dht_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [30:0]   rd_key,
    output logic [31:0]   rd_value,
    output mark_t         rd_mark,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [30:0]   wr_key,
    input  logic [31:0]   wr_value,
    input  mark_t         wr_mark
);
    logic [62:0] kv_mem [DEPTH];
    logic [1:0]  mark_mem [DEPTH];
    logic [DEPTH-1:0] init_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kv_mem[wr_addr]   <= {wr_key, wr_value};
            mark_mem[wr_addr] <= wr_mark;
        end
        {rd_key, rd_value} <= kv_mem[rd_addr];
        rd_mark <= init_reg[rd_addr] ? mark_t'(mark_mem[rd_addr]) : MARK_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg <= '0;
        else if (wr_en)
            init_reg[wr_addr] <= 1'b1;
    end

`ifndef SYNTHESIS
    a_wr_sets_init: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> init_reg[$past(wr_addr)]) else $error("valid bit not set");
    a_wr_mark_used: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_mark != MARK_EMPTY) else $error("write-back clears a slot");
    a_no_x_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !$isunknown(wr_addr)) else $error("unknown write address");
`endif
endmodule

// ===== rtl/core/double_hash_table_top.sv =====
`timescale 1ns / 1ps
// Sequence: the two remainders are computed one after the other, then each probe
//   reads memory (S_READ) and compares (S_CHECK), followed by S_WRITE and S_OUT.
// Requests: one at a time; in_stall is high until the previous result is taken.
//   Both remainders share the bit-serial unit; probes share the one read port.
// Reset: slot marks read as empty, count zero, capacity 60, probe limit 45.
module double_hash_table_top
    import dht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW = $clog2(TABLE_DEPTH),
    parameter int CW = $clog2(TABLE_DEPTH + 1)
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [30:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] read_value,
    output logic [5:0]  slot,
    output logic [6:0]  entry_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    state_t state_reg, state_next;
    logic [6:0]    cap_cfg_reg, lim_cfg_reg;
    logic [CW-1:0] cap_reg;
    logic [6:0]    lim_reg, att_reg;
    logic [1:0]    mode_reg;
    logic [30:0]   key_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] idx_reg, step_reg;
    logic          phase_reg, mod_go_reg, mod_busy_seen_reg;
    logic          hit_reg, empty_reg, del_reg;
    logic [AW-1:0] hit_idx_reg, empty_idx_reg, del_idx_reg;
    logic [31:0]   hval_reg;
    logic [6:0]    count_reg;
    logic [2:0]    st_reg;
    logic [31:0]   rv_reg;
    logic [AW-1:0] slot_reg;
    logic          out_v_reg;

    logic [CW-1:0] cap_eff, mod_div, rem;
    logic [6:0]    lim_eff;
    mod_ctl_t      mctl;
    logic [30:0]   rd_key;
    logic [31:0]   rd_value;
    mark_t         rd_mark;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    mark_t         wr_mark;
    logic [CW:0]   idx_sum;
    logic          accept, stop;

    always_comb
    begin
        if (cap_cfg_reg < 7'd3)
            cap_eff = CW'(3);
        else if ({25'd0, cap_cfg_reg} > 32'(TABLE_DEPTH))
            cap_eff = CW'(TABLE_DEPTH);
        else
            cap_eff = CW'(cap_cfg_reg);
        lim_eff = (lim_cfg_reg == 7'd0) ? 7'd1 : lim_cfg_reg;
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= CAP_RESET;
            lim_cfg_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CAPACITY: cap_cfg_reg <= cfg_data;
                CFG_LIMIT:    lim_cfg_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // first pass: key mod C, second pass: key mod (C - 2)
    assign mod_div = phase_reg ? cap_reg - CW'(2) : cap_reg;

    dht_mod #(.CW(CW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_go_reg), .dividend(key_reg),
        .divisor(mod_div), .ctl(mctl), .rem(rem)
    );

    dht_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
        .clk(clk), .rst_n(rst_n), .rd_addr(idx_reg[AW-1:0]), .rd_key(rd_key),
        .rd_value(rd_value), .rd_mark(rd_mark), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_key(key_reg), .wr_value(val_reg), .wr_mark(wr_mark)
    );

    assign idx_sum = {1'b0, idx_reg} + {1'b0, step_reg};
    assign stop = (rd_mark == MARK_EMPTY)
        || (rd_mark == MARK_USED && rd_key == key_reg)
        || (att_reg + 7'd1 >= lim_reg);

    // write back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_mark = MARK_USED;
        if (state_reg == S_WRITE)
        begin
            if (mode_reg == MODE_WRITE && (hit_reg || del_reg || empty_reg))
            begin
                wr_en = 1'b1;
                wr_addr = hit_reg ? hit_idx_reg : (del_reg ? del_idx_reg : empty_idx_reg);
            end
            else if (mode_reg == MODE_REMOVE && hit_reg)
            begin
                wr_en = 1'b1;
                wr_mark = MARK_DELETED;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MOD;
            S_MOD:   if (phase_reg && mod_busy_seen_reg && !mctl.busy && !mod_go_reg)
                         state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: state_next = stop ? S_WRITE : S_READ;
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (!out_v_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            count_reg <= '0;
            mod_go_reg <= 1'b0;
            phase_reg <= 1'b0;
            mod_busy_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mod_go_reg <= 1'b0;
            if (out_v_reg && !out_stall)
                out_v_reg <= 1'b0;
            if (state_reg == S_IDLE && accept)
            begin
                mod_go_reg <= 1'b1;
                phase_reg  <= 1'b0;
                mod_busy_seen_reg <= 1'b0;
            end
            else if (state_reg == S_MOD)
            begin
                if (mctl.busy)
                    mod_busy_seen_reg <= 1'b1;
                else if (mod_busy_seen_reg && !mod_go_reg && !phase_reg)
                begin
                    // hold first remainder as start index, launch second pass
                    phase_reg <= 1'b1;
                    mod_go_reg <= 1'b1;
                    mod_busy_seen_reg <= 1'b0;
                end
            end
            if (state_reg == S_WRITE)
            begin
                if (mode_reg == MODE_WRITE && !hit_reg && (del_reg || empty_reg))
                    count_reg <= count_reg + 7'd1;
                else if (mode_reg == MODE_REMOVE && hit_reg && count_reg != 7'd0)
                    count_reg <= count_reg - 7'd1;
                out_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            val_reg  <= value;
            cap_reg  <= cap_eff;
            lim_reg  <= lim_eff;
            att_reg  <= '0;
            hit_reg  <= 1'b0;
            empty_reg <= 1'b0;
            del_reg  <= 1'b0;
            hit_idx_reg <= '0;
            empty_idx_reg <= '0;
            del_idx_reg <= '0;
        end
        if (state_reg == S_MOD && !mctl.busy && mod_busy_seen_reg && !mod_go_reg)
        begin
            if (!phase_reg)
                idx_reg <= rem;
            else
                step_reg <= rem + CW'(1);
        end
        if (state_reg == S_CHECK)
        begin
            if (rd_mark == MARK_EMPTY)
            begin
                empty_reg <= 1'b1;
                empty_idx_reg <= idx_reg[AW-1:0];
            end
            else if (rd_mark == MARK_USED && rd_key == key_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= idx_reg[AW-1:0];
                hval_reg <= rd_value;
            end
            else if (rd_mark == MARK_DELETED && !del_reg)
            begin
                del_reg <= 1'b1;
                del_idx_reg <= idx_reg[AW-1:0];
            end
            att_reg <= att_reg + 7'd1;
            idx_reg <= (idx_sum >= {1'b0, cap_reg}) ? CW'(idx_sum - {1'b0, cap_reg})
                                                     : idx_sum[CW-1:0];
        end
        if (state_reg == S_WRITE)
        begin
            rv_reg <= '0;
            slot_reg <= '0;
            if (mode_reg == MODE_WRITE)
            begin
                if (hit_reg)
                begin
                    st_reg <= ST_UPDATED; rv_reg <= val_reg; slot_reg <= hit_idx_reg;
                end
                else if (del_reg || empty_reg)
                begin
                    st_reg <= ST_INSERTED;
                    slot_reg <= del_reg ? del_idx_reg : empty_idx_reg;
                end
                else
                    st_reg <= ST_FULL;
            end
            else if (mode_reg == MODE_REMOVE)
            begin
                st_reg <= hit_reg ? ST_REMOVED : ST_NOT_FOUND;
                if (hit_reg) slot_reg <= hit_idx_reg;
            end
            else
            begin
                st_reg <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                if (hit_reg)
                begin
                    rv_reg <= hval_reg; slot_reg <= hit_idx_reg;
                end
            end
        end
    end

    assign out_valid   = out_v_reg;
    assign status      = st_reg;
    assign read_value  = rv_reg;
    assign slot        = 6'(slot_reg);
    assign entry_count = count_reg;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |=> out_valid) else $error("result not raised");
    a_idle_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> state_reg == S_IDLE) else $error("cfg while busy");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> idx_reg < cap_reg) else $error("probe index out of range");
`endif
endmodule
